>>> hdl/node_lookup_or_insert_table_defines.svh
// Assertion macros for the node lookup-or-insert table.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef NODE_LOOKUP_OR_INSERT_TABLE_DEFINES_SVH
`define NODE_LOOKUP_OR_INSERT_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NLIT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NLIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/nlit_pkg.sv
// Shared types and constants for the node lookup-or-insert table.
// No dependencies; used by nlit_store and the top level.
package nlit_pkg;

  parameter int DEPTH_DEFAULT = 256;

  parameter int ID_W    = 32;
  parameter int KIND_W  = 2;
  parameter int INDEX_W = 8;
  parameter int COUNT_W = 9;

  parameter logic [KIND_W-1:0] KIND_PROCESS = 2'd0;
  parameter logic [KIND_W-1:0] KIND_LOCK    = 2'd1;
  parameter logic [KIND_W-1:0] KIND_REQUEST = 2'd2;

  typedef struct packed {
    logic            is_file;
    logic [ID_W-1:0] id;
  } entry_t;

endpackage

>>> hdl/nlit_store.sv
// Entry memory of the node table: one write port, one read port, read data
// registered and valid in the cycle after the read request. Depends on nlit_pkg.
module nlit_store #(
  parameter int DEPTH  = nlit_pkg::DEPTH_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  nlit_pkg::entry_t     wdata,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    raddr,
  output nlit_pkg::entry_t     rdata
);

  nlit_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/node_lookup_or_insert_table.sv
// Node lookup-or-insert table: top level with the scan sequencer and counters.
// Depends on nlit_pkg, nlit_store and node_lookup_or_insert_table_defines.svh.
// A hit ends the scan at the matching entry; a miss scans every stored entry and then
// inserts in the finish state, which is entered at once when the table is empty.
// busy drops as done rises, and a new request is taken only while busy is low; the
// scan reads one stored entry per cycle through the single read port.
// Reset clears the counters and control; the store keeps its contents, no clear pass.
`include "node_lookup_or_insert_table_defines.svh"

module node_lookup_or_insert_table #(
  parameter int TABLE_DEPTH = nlit_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [nlit_pkg::ID_W-1:0]     node_id,
  input  logic [nlit_pkg::KIND_W-1:0]   node_kind,
  output logic                          done,
  output logic [nlit_pkg::INDEX_W-1:0]  entry_index,
  output logic                          was_new,
  output logic                          table_full,
  output logic [nlit_pkg::COUNT_W-1:0]  process_count,
  output logic [nlit_pkg::COUNT_W-1:0]  lock_file_count,
  output logic [nlit_pkg::COUNT_W-1:0]  request_file_count
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                   state;
  logic [nlit_pkg::ID_W-1:0]    req_id;
  logic [nlit_pkg::KIND_W-1:0]  req_kind;
  logic                         req_file;
  logic [CNT_W-1:0]             entry_count;
  logic [CNT_W-1:0]             processes_seen;
  logic [CNT_W-1:0]             lock_files_seen;
  logic [CNT_W-1:0]             request_files_seen;
  logic [CNT_W-1:0]             issue_ptr;
  logic [ADDR_W-1:0]            rd_ptr;
  logic                         rd_valid;
  logic [nlit_pkg::INDEX_W-1:0] hit_index;
  logic [nlit_pkg::INDEX_W-1:0] new_index;

  logic             accept;
  logic             rd_en;
  logic             wr_en;
  logic             hit;
  logic             last_entry;
  logic             kind_file;
  nlit_pkg::entry_t wr_entry;
  nlit_pkg::entry_t rd_entry;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign kind_file = (node_kind == nlit_pkg::KIND_LOCK) ||
                     (node_kind == nlit_pkg::KIND_REQUEST);

  // Reads stop once every stored entry has been requested.
  assign rd_en      = (state == ST_SCAN) && (issue_ptr != entry_count);
  assign hit        = rd_valid && (rd_entry.id == req_id) && (rd_entry.is_file == req_file);
  assign last_entry = (CNT_W'(rd_ptr) == entry_count - 1'b1);
  assign wr_en      = (state == ST_FINISH) && (entry_count != DEPTH_CNT);

  assign wr_entry.id      = req_id;
  assign wr_entry.is_file = req_file;

  nlit_store #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (entry_count[ADDR_W-1:0]),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (issue_ptr[ADDR_W-1:0]),
    .rdata (rd_entry)
  );

  // Result fields carry only the low bits when the table is deeper than they are wide.
  generate
    if (ADDR_W >= nlit_pkg::INDEX_W) begin : g_idx_trunc
      assign hit_index = rd_ptr[nlit_pkg::INDEX_W-1:0];
      assign new_index = entry_count[nlit_pkg::INDEX_W-1:0];
    end else begin : g_idx_ext
      assign hit_index = {{(nlit_pkg::INDEX_W-ADDR_W){1'b0}}, rd_ptr};
      if (CNT_W >= nlit_pkg::INDEX_W) begin : g_new_trunc
        assign new_index = entry_count[nlit_pkg::INDEX_W-1:0];
      end else begin : g_new_ext
        assign new_index = {{(nlit_pkg::INDEX_W-CNT_W){1'b0}}, entry_count};
      end
    end

    if (CNT_W >= nlit_pkg::COUNT_W) begin : g_cnt_trunc
      assign process_count      = processes_seen[nlit_pkg::COUNT_W-1:0];
      assign lock_file_count    = lock_files_seen[nlit_pkg::COUNT_W-1:0];
      assign request_file_count = request_files_seen[nlit_pkg::COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign process_count      = {{(nlit_pkg::COUNT_W-CNT_W){1'b0}}, processes_seen};
      assign lock_file_count    = {{(nlit_pkg::COUNT_W-CNT_W){1'b0}}, lock_files_seen};
      assign request_file_count = {{(nlit_pkg::COUNT_W-CNT_W){1'b0}}, request_files_seen};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      entry_count        <= '0;
      processes_seen     <= '0;
      lock_files_seen    <= '0;
      request_files_seen <= '0;
      issue_ptr          <= '0;
      rd_valid           <= 1'b0;
      done               <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            issue_ptr <= '0;
            state     <= (entry_count == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            issue_ptr <= issue_ptr + 1'b1;
          end
          if (hit) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else if (rd_valid && last_entry) begin
            state <= ST_FINISH;
          end else begin
            rd_valid <= rd_en;
          end
        end
        ST_FINISH: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (wr_en) begin
            entry_count <= entry_count + 1'b1;
            if (req_kind == nlit_pkg::KIND_LOCK) begin
              lock_files_seen <= lock_files_seen + 1'b1;
            end else if (req_kind == nlit_pkg::KIND_REQUEST) begin
              request_files_seen <= request_files_seen + 1'b1;
            end else begin
              processes_seen <= processes_seen + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request fields and result payload need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_id   <= node_id;
      req_kind <= node_kind;
      req_file <= kind_file;
    end
    if (rd_en) begin
      rd_ptr <= issue_ptr[ADDR_W-1:0];
    end
    if (state == ST_SCAN && hit) begin
      entry_index <= hit_index;
      was_new     <= 1'b0;
      table_full  <= 1'b0;
    end else if (state == ST_FINISH) begin
      entry_index <= wr_en ? new_index : '0;
      was_new     <= wr_en;
      table_full  <= !wr_en;
    end
  end

  `NLIT_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without a request in flight")
  `NLIT_ASSERT_SAME(a_count_bound, 1'b1, entry_count <= DEPTH_CNT, "entry count above depth")
  `NLIT_ASSERT_SAME(a_read_in_scan, rd_valid, state == ST_SCAN, "read data checked outside scan")
  `NLIT_ASSERT_SAME(a_new_grows, done && was_new, entry_count == $past(entry_count) + 1'b1, "insert did not grow the table")
  `NLIT_ASSERT_SAME(a_full_means_full, done && table_full, entry_count == DEPTH_CNT, "full flag with free entries")

endmodule

>>> dv/tb_node_lookup_or_insert_table.sv
// Self-checking testbench for the node lookup-or-insert table.
// Depends on nlit_pkg and node_lookup_or_insert_table; uses its own shadow table to
// predict every result.
`timescale 1ns / 100ps

module tb_node_lookup_or_insert_table;

  localparam int TABLE_DEPTH = nlit_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_REQUESTS = 1234;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_REPORTS = 40;
  localparam logic [nlit_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [nlit_pkg::ID_W-1:0]   id;
    logic [nlit_pkg::KIND_W-1:0] kind;
  } registration_t;

  typedef struct packed {
    logic [nlit_pkg::INDEX_W-1:0] entry_index;
    logic                         was_new;
    logic                         table_full;
    logic [nlit_pkg::COUNT_W-1:0] process_count;
    logic [nlit_pkg::COUNT_W-1:0] lock_file_count;
    logic [nlit_pkg::COUNT_W-1:0] request_file_count;
  } lookup_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [nlit_pkg::ID_W-1:0]     node_id = '0;
  logic [nlit_pkg::KIND_W-1:0]   node_kind = '0;
  logic                          done;
  logic [nlit_pkg::INDEX_W-1:0]  entry_index;
  logic                          was_new;
  logic                          table_full;
  logic [nlit_pkg::COUNT_W-1:0]  process_count;
  logic [nlit_pkg::COUNT_W-1:0]  lock_file_count;
  logic [nlit_pkg::COUNT_W-1:0]  request_file_count;

  registration_t  pending_requests[$];
  registration_t  known_nodes[$];
  lookup_result_t expected_results[$];

  // Shadow copy of the table.
  logic [nlit_pkg::ID_W-1:0] shadow_id[TABLE_DEPTH];
  logic                      shadow_is_file[TABLE_DEPTH];
  int unsigned stored_entries = 0;
  int unsigned processes_seen = 0;
  int unsigned lock_files_seen = 0;
  int unsigned request_files_seen = 0;

  int unsigned accepted_requests = 0;
  int unsigned checked_results = 0;
  int unsigned inserts_seen = 0;
  int unsigned full_rejects_seen = 0;
  int unsigned failures = 0;
  int unsigned cycles = 0;

  node_lookup_or_insert_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .node_id(node_id),
    .node_kind(node_kind),
    .done(done),
    .entry_index(entry_index),
    .was_new(was_new),
    .table_full(table_full),
    .process_count(process_count),
    .lock_file_count(lock_file_count),
    .request_file_count(request_file_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic lookup_result_t register_node(logic [nlit_pkg::ID_W-1:0] id,
                                                   logic [nlit_pkg::KIND_W-1:0] kind);
    lookup_result_t res;
    logic           is_file;
    logic           hit;
    int unsigned    slot;
    is_file = (kind == nlit_pkg::KIND_LOCK) || (kind == nlit_pkg::KIND_REQUEST);
    hit = 1'b0;
    slot = 0;
    for (int unsigned i = 0; i < stored_entries; i++) begin
      if (!hit && shadow_id[i] == id && shadow_is_file[i] == is_file) begin
        hit = 1'b1;
        slot = i;
      end
    end
    res.was_new = 1'b0;
    res.table_full = 1'b0;
    if (!hit) begin
      if (stored_entries < TABLE_DEPTH) begin
        slot = stored_entries;
        shadow_id[slot] = id;
        shadow_is_file[slot] = is_file;
        stored_entries++;
        res.was_new = 1'b1;
        if (kind == nlit_pkg::KIND_LOCK) begin
          lock_files_seen++;
        end else if (kind == nlit_pkg::KIND_REQUEST) begin
          request_files_seen++;
        end else begin
          // The unused kind counts as a process.
          processes_seen++;
        end
      end else begin
        res.table_full = 1'b1;
        slot = 0;
      end
    end
    res.entry_index = slot[nlit_pkg::INDEX_W-1:0];
    res.process_count = processes_seen[nlit_pkg::COUNT_W-1:0];
    res.lock_file_count = lock_files_seen[nlit_pkg::COUNT_W-1:0];
    res.request_file_count = request_files_seen[nlit_pkg::COUNT_W-1:0];
    return res;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
    end
  endfunction

  task automatic queue_request(logic [nlit_pkg::ID_W-1:0] id,
                               logic [nlit_pkg::KIND_W-1:0] kind);
    registration_t req;
    req.id = id;
    req.kind = kind;
    pending_requests.push_back(req);
    known_nodes.push_back(req);
  endtask

  // Request driver: holds a request until the block takes it, idles at random
  // except during one quiet stretch in the middle of the run.
  always @(posedge clk) begin : drive_requests
    registration_t next_req;
    logic          quiet_stretch;
    quiet_stretch = accepted_requests >= 500 && accepted_requests < 700;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(register_node(node_id, node_kind));
        accepted_requests++;
      end
      if (start && busy) begin
        // Request still waiting for the block to take it.
      end else if (pending_requests.size() != 0 &&
                   (quiet_stretch || $urandom_range(99) >= 10)) begin
        next_req = pending_requests.pop_front();
        start <= 1'b1;
        node_id <= next_req.id;
        node_kind <= next_req.kind;
      end else begin
        start <= 1'b0;
        node_id <= $urandom;
        node_kind <= 2'($urandom_range(3));
      end
    end
  end

  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: result with no request outstanding, entry_index %0h",
                 $time, entry_index);
      end else begin
        want = expected_results.pop_front();
        checked_results++;
        if (want.was_new) inserts_seen++;
        if (want.table_full) full_rejects_seen++;
        check_field("entry_index", want.entry_index, entry_index);
        check_field("was_new", want.was_new, was_new);
        check_field("table_full", want.table_full, table_full);
        check_field("process_count", want.process_count, process_count);
        check_field("lock_file_count", want.lock_file_count, lock_file_count);
        check_field("request_file_count", want.request_file_count, request_file_count);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    registration_t               pick;
    int unsigned                 roll;
    logic [nlit_pkg::ID_W-1:0]   id;
    logic [nlit_pkg::KIND_W-1:0] kind;
    logic                        pick_is_file;

    // Directed: id extremes, every kind, class matching across lock and request,
    // and the unused kind matching a process.
    queue_request(32'h0000_0000, nlit_pkg::KIND_PROCESS);
    queue_request(32'h0000_0000, nlit_pkg::KIND_LOCK);
    queue_request(32'h0000_0000, nlit_pkg::KIND_REQUEST);
    queue_request(32'h0000_0000, KIND_UNUSED);
    queue_request(32'hFFFF_FFFF, nlit_pkg::KIND_REQUEST);
    queue_request(32'hFFFF_FFFF, KIND_UNUSED);
    queue_request(32'hFFFF_FFFF, nlit_pkg::KIND_LOCK);
    queue_request(32'hFFFF_FFFF, nlit_pkg::KIND_PROCESS);
    queue_request(32'h8000_0000, KIND_UNUSED);
    queue_request(32'h8000_0000, nlit_pkg::KIND_PROCESS);
    queue_request(32'h7FFF_FFFF, nlit_pkg::KIND_LOCK);
    queue_request(32'hA5A5_A5A5, nlit_pkg::KIND_REQUEST);
    queue_request(32'h5A5A_5A5A, nlit_pkg::KIND_PROCESS);
    queue_request(32'h5A5A_5A5A, nlit_pkg::KIND_LOCK);
    queue_request(32'hA5A5_A5A5, nlit_pkg::KIND_LOCK);
    queue_request(32'h0000_0000, nlit_pkg::KIND_PROCESS);

    // Random: mostly repeats of known nodes, with enough fresh ones to fill the
    // table partway through, so later fresh nodes are turned away.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      roll = $urandom_range(99);
      if (roll < 35) begin
        id = (roll < 4) ? 32'($urandom_range(15)) : 32'($urandom);
        kind = 2'($urandom_range(3));
      end else begin
        pick = known_nodes[$urandom_range(known_nodes.size() - 1)];
        id = pick.id;
        pick_is_file = (pick.kind == nlit_pkg::KIND_LOCK) ||
                       (pick.kind == nlit_pkg::KIND_REQUEST);
        // A few repeats switch class on purpose.
        if (roll >= 90) pick_is_file = !pick_is_file;
        if (pick_is_file) begin
          kind = $urandom_range(1) ? nlit_pkg::KIND_LOCK : nlit_pkg::KIND_REQUEST;
        end else begin
          kind = $urandom_range(1) ? nlit_pkg::KIND_PROCESS : KIND_UNUSED;
        end
      end
      queue_request(id, kind);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TABLE_DEPTH + 10) @(posedge clk);

    $display("checked %0d results from %0d requests: %0d inserts, %0d turned away full",
             checked_results, accepted_requests, inserts_seen, full_rejects_seen);
    $display("final counts: %0d processes, %0d lock files, %0d request files",
             processes_seen, lock_files_seen, request_files_seen);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
